// ===== design/lzrd_pkg.sv =====
package lzrd_pkg;

	localparam int MAX_RUN = 18;
	localparam int MIN_RUN = 3;
	localparam logic [7:0] FILL_CHAR = 8'h20;

	typedef struct packed {
		logic       lit_load;
		logic       start_copy;
		logic       copy_adv;
		logic       restart;
		logic [7:0] data;
		logic [7:0] off_low;
	} lzrd_cmd_t;

	typedef struct packed {
		logic load_ok;
		logic copy_last;
	} lzrd_sts_t;

endpackage

// ===== design/lzrd_if.sv =====
interface lzrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_in;

	modport source(output valid, output in_byte, output last_in, input ready);
	modport sink(input valid, input in_byte, input last_in, output ready);
endinterface

interface lzrd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source(output valid, output out_byte, output last_of_run, input ready);
	modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== design/lzrd_ctrl.sv =====
module lzrd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	lzrd_in_if.sink            rx,
	input  lzrd_pkg::lzrd_sts_t sts,
	output lzrd_pkg::lzrd_cmd_t cmd
);
	import lzrd_pkg::*;

	typedef enum logic {ST_IDLE, ST_COPY} state_t;

	state_t     st_q;
	logic [7:0] flag_bits_q;
	logic [3:0] flags_left_q;
	logic       phase_q;
	logic [7:0] off_q;
	logic       last_pend_q;
	logic       in_ready;
	logic       acc;
	logic       is_flag;

	assign in_ready = (st_q == ST_IDLE) && sts.load_ok;
	assign rx.ready = in_ready;
	assign acc      = rx.valid && in_ready;
	assign is_flag  = (flags_left_q == 4'd0);

	always_comb begin
		cmd            = '0;
		cmd.data       = rx.in_byte;
		cmd.off_low    = off_q;
		unique case (st_q)
			ST_IDLE: begin
				if (acc) begin
					if (phase_q) begin
						cmd.start_copy = 1'b1;
					end else if (!is_flag && flag_bits_q[0]) begin
						cmd.lit_load = 1'b1;
					end
					cmd.restart = rx.last_in && !phase_q;
				end
			end
			ST_COPY: begin
				cmd.copy_adv = sts.load_ok;
				cmd.restart  = sts.load_ok && sts.copy_last && last_pend_q;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			phase_q      <= 1'b0;
			off_q        <= '0;
			last_pend_q  <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						if (cmd.restart) begin
							flag_bits_q  <= '0;
							flags_left_q <= '0;
							phase_q      <= 1'b0;
							off_q        <= '0;
						end else if (phase_q) begin
							flag_bits_q  <= flag_bits_q >> 1;
							flags_left_q <= flags_left_q - 4'd1;
							phase_q      <= 1'b0;
							last_pend_q  <= rx.last_in;
							st_q         <= ST_COPY;
						end else if (is_flag) begin
							flag_bits_q  <= rx.in_byte;
							flags_left_q <= 4'd8;
						end else if (flag_bits_q[0]) begin
							flag_bits_q  <= flag_bits_q >> 1;
							flags_left_q <= flags_left_q - 4'd1;
						end else begin
							off_q   <= rx.in_byte;
							phase_q <= 1'b1;
						end
					end
				end
				ST_COPY: begin
					if (sts.load_ok && sts.copy_last) begin
						st_q <= ST_IDLE;
						if (last_pend_q) begin
							flag_bits_q  <= '0;
							flags_left_q <= '0;
							phase_q      <= 1'b0;
							off_q        <= '0;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_start_enters_copy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_copy |=> (st_q == ST_COPY))
		else $error("copy did not start");
	a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COPY) |-> (!rx.ready && !cmd.lit_load && !cmd.start_copy))
		else $error("token taken during copy");
	a_flags_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flags_left_q <= 4'd8)
		else $error("token count out of range");
`endif
endmodule

// ===== design/lzrd_dp.sv =====
module lzrd_dp #(
	parameter int RING_SIZE = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lzrd_pkg::lzrd_cmd_t cmd,
	output lzrd_pkg::lzrd_sts_t sts,
	lzrd_out_if.source          tx
);
	import lzrd_pkg::*;

	localparam int AW = $clog2(RING_SIZE);
	localparam int FW = AW + 1;
	localparam int TW = $clog2(MAX_RUN);
	localparam int CW = $clog2(MAX_RUN);
	localparam logic [AW-1:0] START_POS = AW'(RING_SIZE - MAX_RUN);

	typedef enum logic [1:0] {RK_MEM, RK_FWD, RK_SPACE, RK_ZERO} rd_kind_t;

	logic [7:0]         mem [RING_SIZE];
	logic [7:0]         rd_q;
	logic [7:0]         fwd_q;
	rd_kind_t           kind_q;
	rd_kind_t           kind_d;
	logic [AW-1:0]      wp_q;
	logic [FW-1:0]      fill_q;
	logic [MAX_RUN-1:0] topv_q;
	logic [AW-1:0]      src_q;
	logic [CW-1:0]      cnt_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic               we;
	logic [7:0]         wdata;
	logic [7:0]         rd_val;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      rd_rel;
	logic [AW-1:0]      wp_rel;

	assign sts.load_ok   = !out_valid_q || tx.ready;
	assign sts.copy_last = (cnt_q == '0);

	assign tx.valid       = out_valid_q;
	assign tx.out_byte    = out_byte_q;
	assign tx.last_of_run = out_last_q;

	always_comb begin
		unique case (kind_q)
			RK_MEM:   rd_val = rd_q;
			RK_FWD:   rd_val = fwd_q;
			RK_SPACE: rd_val = FILL_CHAR;
			RK_ZERO:  rd_val = 8'h00;
			default:  rd_val = rd_q;
		endcase
	end

	assign we    = cmd.lit_load || cmd.copy_adv;
	assign wdata = cmd.lit_load ? cmd.data : rd_val;

	always_comb begin
		if (cmd.start_copy) begin
			rd_addr = AW'({cmd.data[7:4], cmd.off_low});
		end else if (cmd.copy_adv) begin
			rd_addr = src_q + AW'(1);
		end else begin
			rd_addr = src_q;
		end
	end

	assign rd_rel = rd_addr - START_POS;
	assign wp_rel = wp_q - START_POS;

	always_comb begin
		if (we && (rd_addr == wp_q)) begin
			kind_d = RK_FWD;
		end else if (rd_rel < AW'(MAX_RUN)) begin
			kind_d = topv_q[rd_rel[TW-1:0]] ? RK_MEM : RK_ZERO;
		end else if ({1'b0, rd_rel} < fill_q) begin
			kind_d = RK_MEM;
		end else begin
			kind_d = RK_SPACE;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wp_q] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		fwd_q <= wdata;
		if (cmd.lit_load) begin
			out_byte_q <= cmd.data;
			out_last_q <= 1'b1;
		end else if (cmd.copy_adv) begin
			out_byte_q <= rd_val;
			out_last_q <= (cnt_q == '0);
		end
		if (cmd.start_copy) begin
			src_q <= AW'({cmd.data[7:4], cmd.off_low});
		end else if (cmd.copy_adv) begin
			src_q <= src_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= RK_ZERO;
			wp_q        <= START_POS;
			fill_q      <= '0;
			topv_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			kind_q <= kind_d;
			if (we && (wp_rel < AW'(MAX_RUN))) begin
				topv_q[wp_rel[TW-1:0]] <= 1'b1;
			end
			if (cmd.restart) begin
				wp_q   <= START_POS;
				fill_q <= '0;
			end else if (we) begin
				wp_q <= wp_q + AW'(1);
				if (fill_q != FW'(RING_SIZE)) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (cmd.start_copy) begin
				cnt_q <= CW'(cmd.data[3:0]) + CW'(MIN_RUN - 1);
			end else if (cmd.copy_adv) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (we) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(RING_SIZE))
		else $error("fill count overran ring");
	a_restart_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restart |=> (wp_q == START_POS && fill_q == '0))
		else $error("restart did not rewind write position");
	a_copy_end_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy_adv && cnt_q == '0) |=> (tx.valid && tx.last_of_run))
		else $error("final copy beat not marked");
`endif
endmodule

// ===== design/lzss_ring_decoder.sv =====
// An accepted literal shows on the output in the cycle after the accept.
// A reference's second byte starts a copy of 3 to 18 beats; the first goes through the
// ring's read register and output register, then one per cycle while the output is
// not stalled, paced by the ring's single read port; no input is taken during a copy.
// Reset: asynchronous, active low; the ring needs no clearing pass, a fill count and
// valid bits on the top 18 entries supply the space and zero fill at once.
module lzss_ring_decoder #(
	parameter int RING_SIZE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	lzrd_in_if.sink     rx,
	lzrd_out_if.source  tx
);
	import lzrd_pkg::*;

	lzrd_cmd_t cmd;
	lzrd_sts_t sts;

	lzrd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.sts    (sts),
		.cmd    (cmd)
	);

	lzrd_dp #(
		.RING_SIZE (RING_SIZE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.tx     (tx)
	);
endmodule
